@@ src/binary_heap_priority_queue_macros.svh @@
// assertion macros of the heap queue checker
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BHPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bhpq assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BHPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bhpq assertion failed");

`endif

@@ src/bhpq_pkg.sv @@
// shared types, codes and helpers of the binary heap priority queue
`timescale 1ns / 1ps

package bhpq_pkg;

	// fixed field widths
	localparam int KEY_W      = 32;
	localparam int ENTRY_W    = 7;
	localparam int STATUS_W   = 2;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = PADDR_W - 2;

	// default heap depth
	localparam int CAPACITY_DEF = 64;

	typedef logic signed [KEY_W-1:0] key_t;

	// operation codes
	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ORDER_MODE = '0;

	// order modes
	localparam logic MODE_MAX = 1'b0;
	localparam logic MODE_MIN = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} bhpq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_EXT_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_FINISH
	} bhpq_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic up_rd;
		logic up_cmp;
		logic ext_load;
		logic dn_rd;
		logic dn_cmp;
		logic load_out;
	} bhpq_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic up_go;
		logic dn_go;
	} bhpq_flags_t;

	// true when key a belongs strictly above key b; equal keys never move
	function automatic logic ranks_above(input key_t a, input key_t b, input logic mode);
		logic res;
		if (mode == MODE_MIN) begin
			res = (a < b);
		end else begin
			res = (a > b);
		end
		return res;
	endfunction

endpackage

@@ src/bhpq_ctrl.sv @@
// sequencer of the heap queue: accept, sift up or down, deliver one beat
`timescale 1ns / 1ps

module bhpq_ctrl
	import bhpq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	output logic        out_valid,
	input  logic        out_stall,
	input  bhpq_flags_t flags,
	output bhpq_cmd_t   ctl
);

	bhpq_state_t state_q;
	bhpq_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;

	// output register can take a new beat
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					if (cmd == CMD_INSERT) begin
						state_nxt = flags.full ? S_FINISH : S_UP_RD;
					end else begin
						state_nxt = flags.empty ? S_FINISH : S_EXT_LOAD;
					end
				end
			end
			S_UP_RD: begin
				ctl.up_rd = 1'b1;
				state_nxt = flags.at_root ? S_FINISH : S_UP_CMP;
			end
			S_UP_CMP: begin
				ctl.up_cmp = 1'b1;
				state_nxt  = flags.up_go ? S_UP_RD : S_FINISH;
			end
			S_EXT_LOAD: begin
				ctl.ext_load = 1'b1;
				state_nxt    = flags.empty ? S_FINISH : S_DN_RD;
			end
			S_DN_RD: begin
				ctl.dn_rd = 1'b1;
				state_nxt = S_DN_CMP;
			end
			S_DN_CMP: begin
				ctl.dn_cmp = 1'b1;
				state_nxt  = flags.dn_go ? S_DN_RD : S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/bhpq_dpath.sv @@
// heap storage, moving key, cursor and comparators of the heap queue
`timescale 1ns / 1ps

module bhpq_dpath
	import bhpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bhpq_cmd_t                   ctl,
	output bhpq_flags_t                 flags,
	input  logic                        order_mode,
	input  logic                        cmd,
	input  key_t                        key_in,
	output key_t                        taken_key,
	output logic [STATUS_W-1:0]         status,
	output key_t                        top_key,
	output logic                        is_empty,
	output logic [ENTRY_W-1:0]          entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// heap storage, one write and two registered reads a cycle
	key_t mem [CAPACITY];

	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	key_t          cur_q;
	key_t          top_q;
	key_t          taken_q;
	bhpq_status_t  sts_q;
	key_t          rd0_q;
	key_t          rd1_q;

	// result register
	key_t               out_taken_q;
	bhpq_status_t       out_sts_q;
	key_t               out_top_q;
	logic               out_empty_q;
	logic [ENTRY_W-1:0] out_count_q;

	logic [AW-1:0] pos_dec;
	logic [AW-1:0] parent;
	logic [AW+1:0] l_idx;
	logic [AW+1:0] r_idx;
	logic [AW+1:0] count_ext;
	logic [CW-1:0] count_dec;
	logic          l_up;
	logic          r_up;
	logic          up_go;
	logic          dn_go;
	key_t          best_key;
	key_t          dn_key;
	logic [AW-1:0] dn_pos;
	logic [AW-1:0] raddr0;
	logic [AW-1:0] raddr1;
	logic          we;
	logic [AW-1:0] waddr;
	key_t          wdata;
	logic          full;
	logic          empty;

	// tree index arithmetic
	assign pos_dec   = pos_q - AW'(1);
	assign parent    = pos_dec >> 1;
	assign l_idx     = {1'b0, pos_q, 1'b1};
	assign r_idx     = l_idx + (AW+2)'(1);
	assign count_ext = (AW+2)'(count_q);
	assign count_dec = count_q - CW'(1);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);

	// sift up: moving key against its parent
	assign up_go = ranks_above(cur_q, rd0_q, order_mode);

	// sift down: pick the best of moving key and both children
	always_comb begin
		l_up     = (l_idx < count_ext) && ranks_above(rd0_q, cur_q, order_mode);
		best_key = l_up ? rd0_q : cur_q;
		r_up     = (r_idx < count_ext) && ranks_above(rd1_q, best_key, order_mode);
		dn_go    = l_up || r_up;
		dn_key   = r_up ? rd1_q : rd0_q;
		dn_pos   = r_up ? r_idx[AW-1:0] : l_idx[AW-1:0];
	end

	assign flags.full    = full;
	assign flags.empty   = empty;
	assign flags.at_root = (pos_q == '0);
	assign flags.up_go   = up_go;
	assign flags.dn_go   = dn_go;

	// read address select
	always_comb begin
		if (ctl.dn_rd) begin
			raddr0 = l_idx[AW-1:0];
		end else if (ctl.up_rd) begin
			raddr0 = parent;
		end else begin
			raddr0 = AW'(count_dec);
		end
		raddr1 = r_idx[AW-1:0];
	end

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		if (ctl.up_rd && flags.at_root) begin
			we = 1'b1;
		end else if (ctl.up_cmp) begin
			we    = 1'b1;
			wdata = up_go ? rd0_q : cur_q;
		end else if (ctl.dn_cmp) begin
			we    = 1'b1;
			wdata = dn_go ? dn_key : cur_q;
		end
	end

	// storage access
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	// copy of the root slot
	always_ff @(posedge clk) begin
		if (we && (waddr == '0)) begin
			top_q <= wdata;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.accept) begin
			if (cmd == CMD_INSERT && !full) begin
				count_q <= count_q + CW'(1);
			end else if (cmd == CMD_EXTRACT && !empty) begin
				count_q <= count_dec;
			end
		end
	end

	// cursor, moving key, removed key and status of the item at work
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			taken_q <= '0;
			sts_q   <= STS_OK;
			if (cmd == CMD_INSERT) begin
				if (full) begin
					sts_q <= STS_FULL;
				end else begin
					pos_q <= AW'(count_q);
					cur_q <= key_in;
				end
			end else begin
				if (empty) begin
					sts_q <= STS_EMPTY;
				end else begin
					taken_q <= top_q;
				end
			end
		end else if (ctl.ext_load) begin
			cur_q <= rd0_q;
			pos_q <= '0;
		end else if (ctl.up_cmp && up_go) begin
			pos_q <= parent;
		end else if (ctl.dn_cmp && dn_go) begin
			pos_q <= dn_pos;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_taken_q <= taken_q;
			out_sts_q   <= sts_q;
			out_top_q   <= empty ? key_t'(0) : top_q;
			out_empty_q <= empty;
			out_count_q <= ENTRY_W'(count_q);
		end
	end

	assign taken_key   = out_taken_q;
	assign status      = out_sts_q;
	assign top_key     = out_top_q;
	assign is_empty    = out_empty_q;
	assign entry_count = out_count_q;

endmodule

@@ src/binary_heap_priority_queue.sv @@
// top level of the binary heap priority queue with its register port
//
//  channel   signals                                   beat when
//  --------  ----------------------------------------  -------------------------------
//  in        in_valid, in_stall, cmd, key_in           in_valid && !in_stall
//  out       out_valid, out_stall, taken_key, status,  out_valid && !out_stall
//            top_key, is_empty, entry_count
//  apb       psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite
//            prdata, pready                            && pready (write)
//
// One item at a time: a refused item goes straight to the result; an insert climbs level by
// level from its new slot toward the root; an extract that empties the heap finishes without
// sifting, any other moves the last entry to the root and sinks it level by level.
// Each level costs one registered memory read and one compare-and-write.
// in_stall is low only while idle; a waiting result holds the sequencer in its last state.
// Reset empties the heap and selects the max-heap order; storage needs no clearing.
`timescale 1ns / 1ps

module binary_heap_priority_queue
	import bhpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic signed [KEY_W-1:0] key_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [KEY_W-1:0] taken_key,
	output logic [STATUS_W-1:0] status,
	output logic signed [KEY_W-1:0] top_key,
	output logic                is_empty,
	output logic [ENTRY_W-1:0]  entry_count,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	logic                 order_mode_q;
	logic [REG_IDX_W-1:0] reg_idx;
	bhpq_cmd_t            ctl;
	bhpq_flags_t          flags;

	// register port decode
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= MODE_MAX;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_ORDER_MODE) begin
			order_mode_q <= pwdata[0];
		end
	end

	// register read back
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_ORDER_MODE) begin
			prdata[0] = order_mode_q;
		end
	end

	bhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flags     (flags),
		.ctl       (ctl)
	);

	bhpq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.flags       (flags),
		.order_mode  (order_mode_q),
		.cmd         (cmd),
		.key_in      (key_in),
		.taken_key   (taken_key),
		.status      (status),
		.top_key     (top_key),
		.is_empty    (is_empty),
		.entry_count (entry_count)
	);

endmodule

@@ src/bhpq_checker.sv @@
// port-level checks of the heap queue and their binding to the top level
`timescale 1ns / 1ps
`include "binary_heap_priority_queue_macros.svh"

module bhpq_checker
	import bhpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    cmd,
	input logic signed [KEY_W-1:0] key_in,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [KEY_W-1:0] taken_key,
	input logic [STATUS_W-1:0]     status,
	input logic signed [KEY_W-1:0] top_key,
	input logic                    is_empty,
	input logic [ENTRY_W-1:0]      entry_count,
	input logic                    psel,
	input logic                    penable,
	input logic                    pwrite,
	input logic [PADDR_W-1:0]      paddr,
	input logic [PDATA_W-1:0]      pwdata,
	input logic [PDATA_W-1:0]      prdata,
	input logic                    pready
);

	// an accepted item keeps the input closed for at least the next cycle
	`BHPQ_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

	// an extract on an empty heap removes nothing and leaves it empty
	`BHPQ_ASSERT_NOW(a_empty_extract, out_valid && status == STS_EMPTY,
		is_empty && taken_key == '0 && entry_count == '0)

	// a refused insert only happens at full capacity
	`BHPQ_ASSERT_NOW(a_full_insert, out_valid && status == STS_FULL,
		entry_count == ENTRY_W'(CAPACITY) && taken_key == '0)

	// the empty flag and the top agree with the count
	`BHPQ_ASSERT_NOW(a_empty_flag, out_valid && is_empty, entry_count == '0 && top_key == '0)

	// a stalled result beat holds
	`BHPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(taken_key) && $stable(status) && $stable(entry_count))

endmodule

bind binary_heap_priority_queue bhpq_checker #(.CAPACITY(CAPACITY)) u_bhpq_checker (.*);
